// File: rtl/dett_pkg.sv
// ----------------------------------------------------------------------------
// dett_pkg: detection event trigger shared types
// Register map, trigger modes, item and result records, overlap helper.
// ----------------------------------------------------------------------------
`default_nettype none

package dett_pkg;

  // coordinate width used by the watch area overlap test
  localparam int unsigned CoordBits = 16;

  localparam int unsigned CfgIdxBits = 4;
  localparam int unsigned CfgDataBits = 64;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [CoordBits:0]   coord_sum_t;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegEnable        = 4'd0;
  localparam logic [CfgIdxBits-1:0] RegTriggerMode   = 4'd1;
  localparam logic [CfgIdxBits-1:0] RegWantedClass   = 4'd2;
  localparam logic [CfgIdxBits-1:0] RegWantedSource  = 4'd3;
  localparam logic [CfgIdxBits-1:0] RegTriggerLimit  = 4'd4;
  localparam logic [CfgIdxBits-1:0] RegMinConfidence = 4'd5;
  localparam logic [CfgIdxBits-1:0] RegMinSize       = 4'd6;
  localparam logic [CfgIdxBits-1:0] RegWatchArea     = 4'd7;

  // item action codes
  localparam logic ActObject   = 1'b0;
  localparam logic ActFrameEnd = 1'b1;

  typedef enum logic [1:0] {
    MODE_OCCURRENCE = 2'd0,
    MODE_ABSENCE    = 2'd1,
    MODE_SUMMATION  = 2'd2
  } mode_e;

  typedef struct packed {
    logic        enable;
    logic [1:0]  trigger_mode;
    logic [15:0] wanted_class;
    logic [7:0]  wanted_source;
    logic [15:0] trigger_limit;
    logic [15:0] min_confidence;
    logic [31:0] min_size;
    logic [63:0] watch_area;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  frame_source;
    logic [15:0] object_class;
    logic [15:0] object_confidence;
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_width;
    logic [15:0] box_height;
  } item_t;

  typedef struct packed {
    logic        object_passed;
    logic        event_fired;
    logic [15:0] frame_count_seen;
    logic [31:0] events_so_far;
    logic [31:0] events_total;
  } res_t;

  // v lies in [lo, lo + len], sum taken one bit wider so it never wraps
  function automatic logic in_range(coord_t v, coord_t lo, coord_t len);
    coord_sum_t hi;
    hi = {1'b0, lo} + {1'b0, len};
    return (v >= lo) && ({1'b0, v} <= hi);
  endfunction

endpackage

`default_nettype wire

// File: rtl/dett_cfg.sv
// ----------------------------------------------------------------------------
// dett_cfg: configuration register bank
// Holds the trigger settings; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dett_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [dett_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  wire logic [dett_pkg::CfgDataBits-1:0]  cfg_data_i,
  output dett_pkg::cfg_t                         cfg_o
);

  dett_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dett_pkg::RegEnable:        cfg_d.enable         = cfg_data_i[0];
        dett_pkg::RegTriggerMode:   cfg_d.trigger_mode   = cfg_data_i[1:0];
        dett_pkg::RegWantedClass:   cfg_d.wanted_class   = cfg_data_i[15:0];
        dett_pkg::RegWantedSource:  cfg_d.wanted_source  = cfg_data_i[7:0];
        dett_pkg::RegTriggerLimit:  cfg_d.trigger_limit  = cfg_data_i[15:0];
        dett_pkg::RegMinConfidence: cfg_d.min_confidence = cfg_data_i[15:0];
        dett_pkg::RegMinSize:       cfg_d.min_size       = cfg_data_i[31:0];
        dett_pkg::RegWatchArea:     cfg_d.watch_area     = cfg_data_i[63:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable: 1'b1, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/dett_filter.sv
// ----------------------------------------------------------------------------
// dett_filter: object pass criteria
// Enable, limit, class, source, confidence, size and watch area checks.
// ----------------------------------------------------------------------------
`default_nettype none

module dett_filter (
  input  wire dett_pkg::cfg_t   cfg_i,
  input  wire dett_pkg::item_t  item_i,
  input  wire logic [31:0]      fired_count_i,
  output logic                  pass_o
);

  dett_pkg::coord_t bl, bt, bw, bh, al, at, aw, ah;
  logic limit_ok, class_ok, source_ok, conf_ok, size_ok, area_ok;
  logic x_ovl, y_ovl;

  always_comb begin
    bl = dett_pkg::coord_t'(item_i.box_left);
    bt = dett_pkg::coord_t'(item_i.box_top);
    bw = dett_pkg::coord_t'(item_i.box_width);
    bh = dett_pkg::coord_t'(item_i.box_height);
    al = dett_pkg::coord_t'(cfg_i.watch_area[63:48]);
    at = dett_pkg::coord_t'(cfg_i.watch_area[47:32]);
    aw = dett_pkg::coord_t'(cfg_i.watch_area[31:16]);
    ah = dett_pkg::coord_t'(cfg_i.watch_area[15:0]);

    limit_ok  = (cfg_i.trigger_limit == '0) ||
                (fired_count_i < {16'd0, cfg_i.trigger_limit});
    class_ok  = item_i.object_class == cfg_i.wanted_class;
    source_ok = (cfg_i.wanted_source == '0) ||
                (item_i.frame_source == cfg_i.wanted_source);
    conf_ok   = $signed(item_i.object_confidence) >= $signed(cfg_i.min_confidence);
    size_ok   = ((cfg_i.min_size[31:16] == '0) ||
                 (item_i.box_width >= cfg_i.min_size[31:16])) &&
                ((cfg_i.min_size[15:0] == '0) ||
                 (item_i.box_height >= cfg_i.min_size[15:0]));

    x_ovl   = dett_pkg::in_range(bl, al, aw) || dett_pkg::in_range(al, bl, bw);
    y_ovl   = dett_pkg::in_range(bt, at, ah) || dett_pkg::in_range(at, bt, bh);
    // zero area width or height turns the area check off
    area_ok = (aw == '0) || (ah == '0) || (x_ovl && y_ovl);

    pass_o = (item_i.action == dett_pkg::ActObject) && cfg_i.enable && limit_ok &&
             class_ok && source_ok && conf_ok && size_ok && area_ok;
  end

endmodule

`default_nettype wire

// File: rtl/dett_count.sv
// ----------------------------------------------------------------------------
// dett_count: trigger mode logic and event counters
// Decides firing per item and keeps the saturating frame and event counts.
// ----------------------------------------------------------------------------
`default_nettype none

module dett_count (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        action_i,
  input  wire logic        pass_i,
  input  wire logic [1:0]  trigger_mode_i,
  output logic [31:0]      fired_count_o,
  output dett_pkg::res_t   res_o
);

  logic [31:0] fired_q, fired_d;
  logic [31:0] global_q, global_d;
  logic [15:0] pass_cnt_q, pass_cnt_d;
  logic        fire;
  logic [15:0] seen;

  always_comb begin
    fire       = 1'b0;
    pass_cnt_d = pass_cnt_q;
    seen       = pass_cnt_q;
    if (action_i == dett_pkg::ActObject) begin
      if (pass_i) begin
        if (pass_cnt_q != '1) begin
          pass_cnt_d = pass_cnt_q + 16'd1;
        end
        fire = (trigger_mode_i != dett_pkg::MODE_ABSENCE) &&
               (trigger_mode_i != dett_pkg::MODE_SUMMATION);
      end
      seen = pass_cnt_d;
    end else begin
      unique case (trigger_mode_i)
        dett_pkg::MODE_ABSENCE:   fire = (fired_q == '0) && (pass_cnt_q == '0);
        dett_pkg::MODE_SUMMATION: fire = 1'b1;
        default:                  fire = 1'b0;
      endcase
      pass_cnt_d = '0;
    end

    fired_d  = (fire && fired_q != '1) ? fired_q + 32'd1 : fired_q;
    global_d = (fire && global_q != '1) ? global_q + 32'd1 : global_q;

    res_o.object_passed    = pass_i;
    res_o.event_fired      = fire;
    res_o.frame_count_seen = seen;
    res_o.events_so_far    = fired_d;
    res_o.events_total     = global_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fired_q    <= '0;
      global_q   <= '0;
      pass_cnt_q <= '0;
    end else if (step_i) begin
      fired_q    <= fired_d;
      global_q   <= global_d;
      pass_cnt_q <= pass_cnt_d;
    end
  end

  assign fired_count_o = fired_q;

endmodule

`default_nettype wire

// File: rtl/detection_event_trigger_top.sv
// ----------------------------------------------------------------------------
// detection_event_trigger_top: detection event trigger
// Filters object records, raises events by mode and reports the counters.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o   | action, source, class, conf, box
//  out     | out_valid_o / out_ready_i | passed, fired, seen, so_far, total
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One request per cycle while the result is not stalled; each passes the input
//  register, then the result register. The counter update between them sets the rate.
//  A stalled result holds the input stage; both fill before in_ready_o drops.
//  Reset restores enable to 1, other registers and all counters to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module detection_event_trigger_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             action_i,
  input  wire logic [7:0]                       frame_source_i,
  input  wire logic [15:0]                      object_class_i,
  input  wire logic signed [15:0]               object_confidence_i,
  input  wire logic [15:0]                      box_left_i,
  input  wire logic [15:0]                      box_top_i,
  input  wire logic [15:0]                      box_width_i,
  input  wire logic [15:0]                      box_height_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  object_passed_o,
  output logic                                  event_fired_o,
  output logic [15:0]                           frame_count_seen_o,
  output logic [31:0]                           events_so_far_o,
  output logic [31:0]                           events_total_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [dett_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [dett_pkg::CfgDataBits-1:0] cfg_data_i
);

  dett_pkg::cfg_t  cfg;
  dett_pkg::item_t item_q;
  dett_pkg::res_t  res, res_q;
  logic            item_valid_q, item_valid_d;
  logic            out_valid_q, out_valid_d;
  logic            advance, in_fire, step, pass;
  logic [31:0]     fired_count;

  assign cfg_ready_o = 1'b1;

  dett_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !item_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign step       = item_valid_q && advance;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_fire) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
    out_valid_d = advance ? item_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.action            <= action_i;
      item_q.frame_source      <= frame_source_i;
      item_q.object_class      <= object_class_i;
      item_q.object_confidence <= object_confidence_i;
      item_q.box_left          <= box_left_i;
      item_q.box_top           <= box_top_i;
      item_q.box_width         <= box_width_i;
      item_q.box_height        <= box_height_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  dett_filter u_filter (
    .cfg_i         (cfg),
    .item_i        (item_q),
    .fired_count_i (fired_count),
    .pass_o        (pass)
  );

  dett_count u_count (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .action_i       (item_q.action),
    .pass_i         (pass),
    .trigger_mode_i (cfg.trigger_mode),
    .fired_count_o  (fired_count),
    .res_o          (res)
  );

  assign out_valid_o        = out_valid_q;
  assign object_passed_o    = res_q.object_passed;
  assign event_fired_o      = res_q.event_fired;
  assign frame_count_seen_o = res_q.frame_count_seen;
  assign events_so_far_o    = res_q.events_so_far;
  assign events_total_o     = res_q.events_total;

endmodule

`default_nettype wire

// File: rtl/dett_checker.sv
// ----------------------------------------------------------------------------
// dett_checker: port level checks for the detection event trigger
// Result consistency and output hold, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dett_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        object_passed_o,
  input wire logic        event_fired_o,
  input wire logic [15:0] frame_count_seen_o,
  input wire logic [31:0] events_so_far_o,
  input wire logic [31:0] events_total_o
);

  // a passing object is already part of the reported frame count
  a_pass_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && object_passed_o |-> frame_count_seen_o != 16'd0)
    else $error("passed object not in frame count");

  // trigger and global tallies move together from reset
  a_tallies_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> events_so_far_o == events_total_o)
    else $error("event tallies diverge");

  a_fired_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_fired_o |-> events_total_o != 32'd0)
    else $error("event raised but tally is zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(events_total_o) &&
      $stable(frame_count_seen_o) && $stable(event_fired_o))
    else $error("stalled result changed");

endmodule

bind detection_event_trigger_top dett_checker u_dett_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .object_passed_o    (object_passed_o),
  .event_fired_o      (event_fired_o),
  .frame_count_seen_o (frame_count_seen_o),
  .events_so_far_o    (events_so_far_o),
  .events_total_o     (events_total_o)
);

`default_nettype wire

// File: sim/detection_event_trigger_top_tb.sv
// ----------------------------------------------------------------------------
// detection_event_trigger_top_tb: self-checking bench for the event trigger
// Drives object and frame-end requests with random idling on both channels,
// rewrites the registers between phases, predicts every result in-bench and
// compares each returned result field by field in arrival order.
// ----------------------------------------------------------------------------
module detection_event_trigger_top_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHoldCycles = 80;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned PhaseReqs = 62;
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef logic [dett_pkg::CfgIdxBits-1:0] cfg_idx_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0;
  logic in_ready_o;
  dett_pkg::item_t cur_req = '0;

  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic object_passed_o;
  logic event_fired_o;
  logic [15:0] frame_count_seen_o;
  logic [31:0] events_so_far_o;
  logic [31:0] events_total_o;

  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [dett_pkg::CfgIdxBits-1:0] cfg_index_i = '0;
  logic [dett_pkg::CfgDataBits-1:0] cfg_data_i = '0;

  // bench state
  dett_pkg::item_t pending_reqs[$];
  dett_pkg::res_t expected_results[$];
  bit req_offered = 1'b0;
  bit idle_on = 1'b1;
  bit sink_hold = 1'b0;
  int unsigned send_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned cycle_cnt = 0;
  event hold_sink_ev;

  // predictor copy of registers and counters
  dett_pkg::cfg_t trig_cfg;
  logic [31:0] fired_cnt = '0;
  logic [15:0] pass_cnt = '0;
  logic [31:0] total_cnt = '0;

  detection_event_trigger_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (cur_req.action),
    .frame_source_i      (cur_req.frame_source),
    .object_class_i      (cur_req.object_class),
    .object_confidence_i (cur_req.object_confidence),
    .box_left_i          (cur_req.box_left),
    .box_top_i           (cur_req.box_top),
    .box_width_i         (cur_req.box_width),
    .box_height_i        (cur_req.box_height),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .object_passed_o     (object_passed_o),
    .event_fired_o       (event_fired_o),
    .frame_count_seen_o  (frame_count_seen_o),
    .events_so_far_o     (events_so_far_o),
    .events_total_o      (events_total_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // v in [lo, lo + len], end point kept one bit wider
  function automatic bit in_span(logic [15:0] v, logic [15:0] lo, logic [15:0] len);
    logic [16:0] span_end;
    span_end = {1'b0, lo} + {1'b0, len};
    return (v >= lo) && ({1'b0, v} <= span_end);
  endfunction

  function automatic bit object_qualifies(dett_pkg::item_t it);
    logic [15:0] al, at, aw, ah;
    bit x_hit, y_hit;
    al = trig_cfg.watch_area[63:48];
    at = trig_cfg.watch_area[47:32];
    aw = trig_cfg.watch_area[31:16];
    ah = trig_cfg.watch_area[15:0];
    if (!trig_cfg.enable) return 1'b0;
    if (trig_cfg.trigger_limit != 0 && fired_cnt >= trig_cfg.trigger_limit) return 1'b0;
    if (it.object_class != trig_cfg.wanted_class) return 1'b0;
    if (trig_cfg.wanted_source != 0 && it.frame_source != trig_cfg.wanted_source)
      return 1'b0;
    if ($signed(it.object_confidence) < $signed(trig_cfg.min_confidence)) return 1'b0;
    if (trig_cfg.min_size[31:16] != 0 && it.box_width < trig_cfg.min_size[31:16])
      return 1'b0;
    if (trig_cfg.min_size[15:0] != 0 && it.box_height < trig_cfg.min_size[15:0])
      return 1'b0;
    if (aw != 0 && ah != 0) begin
      x_hit = in_span(it.box_left, al, aw) || in_span(al, it.box_left, it.box_width);
      y_hit = in_span(it.box_top, at, ah) || in_span(at, it.box_top, it.box_height);
      if (!(x_hit && y_hit)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic dett_pkg::res_t predict_trigger(dett_pkg::item_t it);
    dett_pkg::res_t r;
    r = '0;
    if (it.action == dett_pkg::ActObject) begin
      if (object_qualifies(it)) begin
        r.object_passed = 1'b1;
        if (pass_cnt != 16'hFFFF) pass_cnt++;
        // mode 3 falls back to occurrence
        r.event_fired = trig_cfg.trigger_mode != dett_pkg::MODE_ABSENCE &&
                        trig_cfg.trigger_mode != dett_pkg::MODE_SUMMATION;
      end
      r.frame_count_seen = pass_cnt;
    end else begin
      r.frame_count_seen = pass_cnt;
      if (trig_cfg.trigger_mode == dett_pkg::MODE_ABSENCE)
        r.event_fired = fired_cnt == 0 && pass_cnt == 0;
      else if (trig_cfg.trigger_mode == dett_pkg::MODE_SUMMATION)
        r.event_fired = 1'b1;
      pass_cnt = '0;
    end
    if (r.event_fired) begin
      if (fired_cnt != 32'hFFFF_FFFF) fired_cnt++;
      if (total_cnt != 32'hFFFF_FFFF) total_cnt++;
    end
    r.events_so_far = fired_cnt;
    r.events_total = total_cnt;
    return r;
  endfunction

  // ------------------------------------------------------------ driver/monitor

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_trigger(cur_req));
        req_offered = 1'b0;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          req_offered = 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string msg);
    $display("ERROR: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic check_result(dett_pkg::res_t got);
    dett_pkg::res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with none expected", result_cnt));
    end else begin
      want = expected_results.pop_front();
      if (got.object_passed !== want.object_passed)
        report_mismatch($sformatf("result %0d object_passed %0b, want %0b",
                                  result_cnt, got.object_passed, want.object_passed));
      if (got.event_fired !== want.event_fired)
        report_mismatch($sformatf("result %0d event_fired %0b, want %0b",
                                  result_cnt, got.event_fired, want.event_fired));
      if (got.frame_count_seen !== want.frame_count_seen)
        report_mismatch($sformatf("result %0d frame_count_seen %0d, want %0d",
                                  result_cnt, got.frame_count_seen, want.frame_count_seen));
      if (got.events_so_far !== want.events_so_far)
        report_mismatch($sformatf("result %0d events_so_far %0d, want %0d",
                                  result_cnt, got.events_so_far, want.events_so_far));
      if (got.events_total !== want.events_total)
        report_mismatch($sformatf("result %0d events_total %0d, want %0d",
                                  result_cnt, got.events_total, want.events_total));
    end
    result_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        check_result({object_passed_o, event_fired_o, frame_count_seen_o,
                      events_so_far_o, events_total_o});
      if (sink_hold) begin
        out_ready_i <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 7);
      end
    end
  end

  // long receiver stall so both pipeline stages fill and in_ready_o drops
  always begin
    @(hold_sink_ev);
    sink_hold <= 1'b1;
    repeat (LongHoldCycles) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  // ----------------------------------------------------------------- stimulus

  task automatic write_reg(cfg_idx_t idx, logic [dett_pkg::CfgDataBits-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      dett_pkg::RegEnable:        trig_cfg.enable = val[0];
      dett_pkg::RegTriggerMode:   trig_cfg.trigger_mode = val[1:0];
      dett_pkg::RegWantedClass:   trig_cfg.wanted_class = val[15:0];
      dett_pkg::RegWantedSource:  trig_cfg.wanted_source = val[7:0];
      dett_pkg::RegTriggerLimit:  trig_cfg.trigger_limit = val[15:0];
      dett_pkg::RegMinConfidence: trig_cfg.min_confidence = val[15:0];
      dett_pkg::RegMinSize:       trig_cfg.min_size = val[31:0];
      dett_pkg::RegWatchArea:     trig_cfg.watch_area = val;
      default: ;
    endcase
  endtask

  // wait until every request is taken and every result is back
  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || req_offered || expected_results.size() != 0);
  endtask

  // random bits above the register width; the block must drop them
  function automatic logic [63:0] pad_junk(logic [63:0] v, int unsigned w);
    logic [63:0] j;
    j = {$urandom, $urandom};
    return v | (j << w);
  endfunction

  function automatic dett_pkg::item_t object_req(logic [7:0] src, logic [15:0] cls,
                                                 logic [15:0] conf,
                                                 logic [15:0] l, logic [15:0] t,
                                                 logic [15:0] w, logic [15:0] h);
    dett_pkg::item_t it;
    it.action = dett_pkg::ActObject;
    it.frame_source = src;
    it.object_class = cls;
    it.object_confidence = conf;
    it.box_left = l;
    it.box_top = t;
    it.box_width = w;
    it.box_height = h;
    return it;
  endfunction

  // frame fields are ignored, so fill them with noise
  function automatic dett_pkg::item_t frame_end_req();
    dett_pkg::item_t it;
    it = dett_pkg::item_t'({$urandom, $urandom, $urandom, $urandom});
    it.action = dett_pkg::ActFrameEnd;
    return it;
  endfunction

  function automatic dett_pkg::item_t random_object();
    dett_pkg::item_t it;
    it = dett_pkg::item_t'({$urandom, $urandom, $urandom, $urandom});
    it.action = dett_pkg::ActObject;
    if (trig_cfg.wanted_source != 0 && $urandom_range(0, 3) != 0)
      it.frame_source = trig_cfg.wanted_source;
    if ($urandom_range(0, 7) != 0) it.object_class = trig_cfg.wanted_class;
    if ($urandom_range(0, 4) != 0) begin
      it.box_left = 16'($urandom_range(0, 1600));
      it.box_top = 16'($urandom_range(0, 1600));
      it.box_width = 16'($urandom_range(0, 600));
      it.box_height = 16'($urandom_range(0, 600));
    end
    return it;
  endfunction

  task automatic shuffle_settings();
    logic [15:0] lim;
    logic [63:0] area;
    lim = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'(fired_cnt + $urandom_range(1, 30));
    if ($urandom_range(0, 2) == 0)
      area = '0;
    else if ($urandom_range(0, 7) == 0)
      area = {$urandom, $urandom};
    else
      area = {16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)),
              16'($urandom_range(0, 500)), 16'($urandom_range(0, 500))};
    write_reg(dett_pkg::RegEnable, pad_junk(64'($urandom_range(0, 7) != 0), 1));
    write_reg(dett_pkg::RegTriggerMode, pad_junk(64'($urandom_range(0, 3)), 2));
    write_reg(dett_pkg::RegWantedClass, pad_junk(64'(16'($urandom)), 16));
    write_reg(dett_pkg::RegWantedSource,
              pad_junk(64'(($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom)), 8));
    write_reg(dett_pkg::RegTriggerLimit, pad_junk(64'(lim), 16));
    write_reg(dett_pkg::RegMinConfidence, pad_junk(64'(16'($urandom)), 16));
    write_reg(dett_pkg::RegMinSize,
              pad_junk(64'({($urandom_range(0, 1) == 0) ? 16'd0
                                                        : 16'($urandom_range(0, 300)),
                            ($urandom_range(0, 1) == 0) ? 16'd0
                                                        : 16'($urandom_range(0, 300))}),
                       32));
    write_reg(dett_pkg::RegWatchArea, area);
    if ($urandom_range(0, 2) == 0)
      write_reg(cfg_idx_t'($urandom_range(dett_pkg::RegWatchArea + 1,
                                          2 ** dett_pkg::CfgIdxBits - 1)),
                {$urandom, $urandom});
  endtask

  initial begin
    trig_cfg = '0;
    trig_cfg.enable = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // absence mode first, while no event has been raised yet
    write_reg(dett_pkg::RegTriggerMode, 64'(dett_pkg::MODE_ABSENCE));
    write_reg(dett_pkg::RegWantedClass, 64'h1234);
    pending_reqs.push_back(object_req(8'h01, 16'h1234, 16'h4000, 16'd10, 16'd10, 16'd5, 16'd5));
    pending_reqs.push_back(frame_end_req());  // passing object seen: no event
    pending_reqs.push_back(frame_end_req());  // empty frame: fires once
    pending_reqs.push_back(frame_end_req());
    pending_reqs.push_back(object_req(8'h00, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0));
    drain();

    // extreme settings, area at the top of the coordinate range
    write_reg(dett_pkg::RegEnable, 64'd1);
    write_reg(dett_pkg::RegTriggerMode, 64'(dett_pkg::MODE_OCCURRENCE));
    write_reg(dett_pkg::RegWantedClass, 64'hFFFF);
    write_reg(dett_pkg::RegWantedSource, 64'hFF);
    write_reg(dett_pkg::RegTriggerLimit, 64'hFFFF);
    write_reg(dett_pkg::RegMinConfidence, 64'h8000);
    write_reg(dett_pkg::RegMinSize, 64'h0001_0001);
    write_reg(dett_pkg::RegWatchArea, '1);
    pending_reqs.push_back(object_req(8'hFF, 16'hFFFF, 16'h7FFF, '1, '1, '1, '1));
    pending_reqs.push_back(object_req(8'h7F, 16'hFFFF, 16'h7FFF, '1, '1, '1, '1));
    pending_reqs.push_back(object_req(8'hFF, 16'hFFFF, 16'h8000, 16'd0, '1, '1, 16'd1));
    pending_reqs.push_back(object_req(8'hFF, 16'hFFFF, 16'h0000, 16'd0, '1, 16'hFFFE, 16'd1));
    pending_reqs.push_back(object_req(8'hFF, 16'hFFFF, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0));
    pending_reqs.push_back(object_req(8'hFF, 16'hFFFE, 16'h0000, '1, '1, '1, '1));
    pending_reqs.push_back(frame_end_req());
    pending_reqs.push_back(frame_end_req());
    drain();

    // disabled, unused mode, strictest minimums
    write_reg(dett_pkg::RegEnable, 64'd0);
    write_reg(dett_pkg::RegTriggerMode, 64'(ModeUnused));
    write_reg(dett_pkg::RegWantedClass, 64'd0);
    write_reg(dett_pkg::RegWantedSource, 64'd0);
    write_reg(dett_pkg::RegTriggerLimit, 64'd0);
    write_reg(dett_pkg::RegMinConfidence, 64'h7FFF);
    write_reg(dett_pkg::RegMinSize, 64'hFFFF_FFFF);
    write_reg(dett_pkg::RegWatchArea, 64'd0);
    pending_reqs.push_back(object_req(8'h00, 16'h0000, 16'h7FFF, 16'd0, 16'd0, '1, '1));
    pending_reqs.push_back(frame_end_req());
    drain();
    write_reg(dett_pkg::RegEnable, 64'd1);
    pending_reqs.push_back(object_req(8'h00, 16'h0000, 16'h7FFF, 16'd0, 16'd0, '1, '1));
    pending_reqs.push_back(object_req(8'h00, 16'h0000, 16'h7FFE, 16'd0, 16'd0, '1, '1));
    pending_reqs.push_back(frame_end_req());
    drain();

    // limit already reached: objects blocked, summation still fires
    write_reg(dett_pkg::RegTriggerMode, 64'(dett_pkg::MODE_SUMMATION));
    write_reg(dett_pkg::RegTriggerLimit, 64'd1);
    pending_reqs.push_back(object_req(8'h00, 16'h0000, 16'h7FFF, 16'd0, 16'd0, '1, '1));
    pending_reqs.push_back(frame_end_req());
    drain();

    for (int p = 0; p < RandPhases; p++) begin
      shuffle_settings();
      if (p == RandPhases - 1) idle_on <= 1'b0;
      @(posedge clk_i);
      for (int i = 0; i < PhaseReqs; i++)
        pending_reqs.push_back(($urandom_range(0, 5) == 0) ? frame_end_req() : random_object());
      if (p == 2) -> hold_sink_ev;
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
